>>> rtl/spf_pkg.sv
`timescale 1ns / 1ps

package spf_pkg;

    // Width of every coordinate and colour field on the ports, and of the configuration data.
    localparam int FIELD_W = 16;

    // Default coordinate width; the datapath masks coordinates and configuration values to it.
    localparam int COORD_BITS_DEF = 16;

    // Restoring division steps done in one divider stage.
    localparam int DIV_STEPS = 4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_W = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_H = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_W    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_H    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_W    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_H    = 3'd7;

    // One source pixel beat.
    typedef struct packed {
        logic [FIELD_W-1:0] source_col;
        logic [FIELD_W-1:0] source_row;
        logic [FIELD_W-1:0] color_in;
    } t_spf_in;

    // One footprint result beat.
    typedef struct packed {
        logic               is_empty;
        logic [FIELD_W-1:0] col_start;
        logic [FIELD_W-1:0] col_end;
        logic [FIELD_W-1:0] row_start;
        logic [FIELD_W-1:0] row_end;
        logic [FIELD_W-1:0] color_out;
    } t_spf_out;

endpackage

>>> rtl/spf_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider: up to STEPS quotient bits per stage.
module spf_div #(
    parameter int COORD_BITS = spf_pkg::COORD_BITS_DEF,
    parameter int STEPS      = spf_pkg::DIV_STEPS
) (
    input  logic                  i_clk,
    input  logic [2*COORD_BITS:0] i_num,
    input  logic [COORD_BITS-1:0] i_den,
    output logic [2*COORD_BITS:0] o_quo
);

    localparam int W  = 2 * COORD_BITS + 1;
    localparam int NS = (W + STEPS - 1) / STEPS;

    logic [COORD_BITS-1:0] r_rem [NS];
    logic [W-1:0]          r_nq  [NS];

    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_stage
            logic [COORD_BITS-1:0] w_rem_in;
            logic [W-1:0]          w_nq_in;
            logic [COORD_BITS:0]   v_sh;
            logic [COORD_BITS-1:0] n_rem;
            logic [W-1:0]          n_nq;

            if (g == 0) begin : g_first
                assign w_rem_in = '0;
                assign w_nq_in  = i_num;
            end else begin : g_next
                assign w_rem_in = r_rem[g-1];
                assign w_nq_in  = r_nq[g-1];
            end

            // Shift in one numerator bit per step and subtract when it fits.
            always_comb begin
                n_rem = w_rem_in;
                n_nq  = w_nq_in;
                v_sh  = '0;
                for (int j = 0; j < STEPS; j++) begin
                    if (g * STEPS + j < W) begin
                        v_sh = {n_rem, n_nq[W-1]};
                        n_nq = {n_nq[W-2:0], 1'b0};
                        if (v_sh >= {1'b0, i_den}) begin
                            v_sh    = v_sh - {1'b0, i_den};
                            n_nq[0] = 1'b1;
                        end
                        n_rem = v_sh[COORD_BITS-1:0];
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[g] <= n_rem;
                r_nq[g]  <= n_nq;
            end
        end
    endgenerate

    assign o_quo = r_nq[NS-1];

endmodule

>>> rtl/spf_span.sv
`timescale 1ns / 1ps

// One axis of the footprint: offset, minimum width of one, clip, emptiness.
module spf_span #(
    parameter int COORD_BITS = spf_pkg::COORD_BITS_DEF
) (
    input  logic [2*COORD_BITS:0] i_q_lo,
    input  logic [2*COORD_BITS:0] i_q_hi,
    input  logic [COORD_BITS-1:0] i_org,
    input  logic [COORD_BITS-1:0] i_clip,
    output logic                  o_ok,
    output logic [COORD_BITS-1:0] o_start,
    output logic [COORD_BITS-1:0] o_end
);

    localparam int W  = 2 * COORD_BITS + 1;
    localparam int AW = W + 2;

    logic [AW-1:0] w_a;
    logic [AW-1:0] w_b;
    logic [AW-1:0] w_b_min;
    logic [AW-1:0] w_b_clip;
    logic [AW-1:0] w_clip;

    assign w_a    = AW'(i_org) + AW'(i_q_lo);
    assign w_b    = AW'(i_org) + AW'(i_q_hi);
    assign w_clip = AW'(i_clip);

    // A span is at least one pixel wide, then its end is clipped to the canvas.
    always_comb begin
        w_b_min  = (w_b <= w_a) ? (w_a + AW'(1)) : w_b;
        w_b_clip = (w_b_min > w_clip) ? w_clip : w_b_min;
    end

    assign o_ok    = (w_a < w_b_clip);
    assign o_start = w_a[COORD_BITS-1:0];
    assign o_end   = w_b_clip[COORD_BITS-1:0];

endmodule

>>> rtl/scaled_pixel_footprint.sv
`timescale 1ns / 1ps

// Scaled pixel footprint. Each source pixel beat gives one footprint beat on
// o_res, marked by o_res_vld for exactly one cycle; the receiver cannot stall
// it and must take every beat. A new beat is taken every cycle in which start
// is high (busy is always low). Each beat passes through the input, product
// and numerator registers, the pipelined divider, four quotient bits per
// stage, and the output register. Write configuration only while no beat is
// in flight.
module scaled_pixel_footprint #(
    parameter int COORD_BITS = spf_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  spf_pkg::t_spf_in                   i_pix,
    output logic                               o_res_vld,
    output spf_pkg::t_spf_out                  o_res,
    input  logic                               i_cfg_we,
    input  logic [spf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [spf_pkg::FIELD_W-1:0]        i_cfg_data
);

    localparam int CB = COORD_BITS;
    localparam int W  = 2 * CB + 1;
    localparam int NS = (W + spf_pkg::DIV_STEPS - 1) / spf_pkg::DIV_STEPS;
    localparam int D  = NS + 3;
    localparam int FW = spf_pkg::FIELD_W;

    // Configuration registers.
    logic [CB-1:0] r_cw, r_ch, r_fx, r_fy, r_fw, r_fh, r_sw, r_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw <= '0; r_ch <= '0; r_fx <= '0; r_fy <= '0;
            r_fw <= '0; r_fh <= '0; r_sw <= '0; r_sh <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                spf_pkg::CFG_CANVAS_W: r_cw <= i_cfg_data[CB-1:0];
                spf_pkg::CFG_CANVAS_H: r_ch <= i_cfg_data[CB-1:0];
                spf_pkg::CFG_FIT_X:    r_fx <= i_cfg_data[CB-1:0];
                spf_pkg::CFG_FIT_Y:    r_fy <= i_cfg_data[CB-1:0];
                spf_pkg::CFG_FIT_W:    r_fw <= i_cfg_data[CB-1:0];
                spf_pkg::CFG_FIT_H:    r_fh <= i_cfg_data[CB-1:0];
                spf_pkg::CFG_SRC_W:    r_sw <= i_cfg_data[CB-1:0];
                spf_pkg::CFG_SRC_H:    r_sh <= i_cfg_data[CB-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Input stage.
    logic          r_a_vld;
    logic [CB-1:0] r_a_col, r_a_row;
    logic [FW-1:0] r_a_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_col   <= i_pix.source_col[CB-1:0];
        r_a_row   <= i_pix.source_row[CB-1:0];
        r_a_color <= i_pix.color_in;
    end

    // Product stage: pos * fit and (pos + 1) * fit for both axes.
    logic [W-1:0] r_px_lo, r_px_hi, r_py_lo, r_py_hi;

    always_ff @(posedge i_clk) begin
        r_px_lo <= W'(r_a_col) * W'(r_fw);
        r_px_hi <= (W'(r_a_col) + W'(1)) * W'(r_fw);
        r_py_lo <= W'(r_a_row) * W'(r_fh);
        r_py_hi <= (W'(r_a_row) + W'(1)) * W'(r_fh);
    end

    // Numerator stage: the end edge rounds up.
    logic [W-1:0] r_nx_lo, r_nx_hi, r_ny_lo, r_ny_hi;

    always_ff @(posedge i_clk) begin
        r_nx_lo <= r_px_lo;
        r_nx_hi <= r_px_hi + W'(r_sw) - W'(1);
        r_ny_lo <= r_py_lo;
        r_ny_hi <= r_py_hi + W'(r_sh) - W'(1);
    end

    // Four dividers in lockstep.
    logic [W-1:0] w_qx_lo, w_qx_hi, w_qy_lo, w_qy_hi;

    spf_div #(.COORD_BITS(CB), .STEPS(spf_pkg::DIV_STEPS)) u_div_xl (
        .i_clk(i_clk), .i_num(r_nx_lo), .i_den(r_sw), .o_quo(w_qx_lo));
    spf_div #(.COORD_BITS(CB), .STEPS(spf_pkg::DIV_STEPS)) u_div_xh (
        .i_clk(i_clk), .i_num(r_nx_hi), .i_den(r_sw), .o_quo(w_qx_hi));
    spf_div #(.COORD_BITS(CB), .STEPS(spf_pkg::DIV_STEPS)) u_div_yl (
        .i_clk(i_clk), .i_num(r_ny_lo), .i_den(r_sh), .o_quo(w_qy_lo));
    spf_div #(.COORD_BITS(CB), .STEPS(spf_pkg::DIV_STEPS)) u_div_yh (
        .i_clk(i_clk), .i_num(r_ny_hi), .i_den(r_sh), .o_quo(w_qy_hi));

    // Spans of both axes.
    logic          w_okx, w_oky;
    logic [CB-1:0] w_xs, w_xe, w_ys, w_ye;

    spf_span #(.COORD_BITS(CB)) u_span_x (
        .i_q_lo(w_qx_lo), .i_q_hi(w_qx_hi), .i_org(r_fx), .i_clip(r_cw),
        .o_ok(w_okx), .o_start(w_xs), .o_end(w_xe));
    spf_span #(.COORD_BITS(CB)) u_span_y (
        .i_q_lo(w_qy_lo), .i_q_hi(w_qy_hi), .i_org(r_fy), .i_clip(r_ch),
        .o_ok(w_oky), .o_start(w_ys), .o_end(w_ye));

    // Valid bits and colour travel alongside the datapath.
    logic          r_dv   [D];
    logic [FW-1:0] r_dcol [D-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < D; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else begin
            r_dv[0] <= r_a_vld;
            for (int k = 1; k < D; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dcol[0] <= r_a_color;
        for (int k = 1; k < D - 1; k++) begin
            r_dcol[k] <= r_dcol[k-1];
        end
    end

    // Output register: an empty footprint reports zero edges.
    logic              w_empty;
    spf_pkg::t_spf_out n_res;
    spf_pkg::t_spf_out r_res;

    always_comb begin
        w_empty = (r_fw == '0) || (r_fh == '0) || (r_sw == '0) || (r_sh == '0)
                  || !w_okx || !w_oky;
        n_res.is_empty  = w_empty;
        n_res.col_start = w_empty ? '0 : FW'(w_xs);
        n_res.col_end   = w_empty ? '0 : FW'(w_xe);
        n_res.row_start = w_empty ? '0 : FW'(w_ys);
        n_res.row_end   = w_empty ? '0 : FW'(w_ye);
        n_res.color_out = r_dcol[D-2];
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res     = r_res;
    assign o_res_vld = r_dv[D-1];

endmodule

>>> dv/scaled_pixel_footprint_tb.sv
`timescale 1ns / 1ps

module scaled_pixel_footprint_tb;

    localparam int LATENCY   = 12;
    localparam int WATCHDOG  = 2000;
    localparam int N_RANDOM  = 550;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    spf_pkg::t_spf_in  i_pix;
    logic              o_res_vld;
    spf_pkg::t_spf_out o_res;
    logic              i_cfg_we;
    logic [spf_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [spf_pkg::FIELD_W-1:0]   i_cfg_data;

    scaled_pixel_footprint dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_pix      (i_pix),
        .o_res_vld  (o_res_vld),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Free-running 10 ns clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Shadow copy of the geometry registers, indexed by register number.
    logic [15:0] geom [8];

    spf_pkg::t_spf_out footprint_q [$];
    int       n_fail;
    int       n_beats;
    int       n_empty;
    int       idle_cycles;
    bit       gaps_on;

    // One axis of the footprint; returns 0 when the span clips away.
    function automatic bit axis_span(input logic [15:0] pos, input logic [15:0] org,
                                     input logic [15:0] fsz, input logic [15:0] ssz,
                                     input logic [15:0] clip,
                                     output logic [15:0] s, output logic [15:0] e);
        logic [63:0] a;
        logic [63:0] b;
        a = 64'(org) + (64'(pos) * 64'(fsz)) / 64'(ssz);
        b = 64'(org) + ((64'(pos) + 64'd1) * 64'(fsz) + 64'(ssz) - 64'd1) / 64'(ssz);
        if (b <= a) b = a + 64'd1;
        if (b > 64'(clip)) b = 64'(clip);
        s = a[15:0];
        e = b[15:0];
        return a < b;
    endfunction

    function automatic spf_pkg::t_spf_out pixel_footprint(input spf_pkg::t_spf_in px);
        spf_pkg::t_spf_out r;
        bit       ok;
        logic [15:0] cs, ce, rs, re;
        r = '0;
        r.is_empty = 1'b1;
        r.color_out = px.color_in;
        ok = 1'b0;
        if (geom[spf_pkg::CFG_FIT_W] != 0 && geom[spf_pkg::CFG_FIT_H] != 0 &&
            geom[spf_pkg::CFG_SRC_W] != 0 && geom[spf_pkg::CFG_SRC_H] != 0) begin
            ok = axis_span(px.source_col, geom[spf_pkg::CFG_FIT_X],
                           geom[spf_pkg::CFG_FIT_W], geom[spf_pkg::CFG_SRC_W],
                           geom[spf_pkg::CFG_CANVAS_W], cs, ce);
            if (ok)
                ok = axis_span(px.source_row, geom[spf_pkg::CFG_FIT_Y],
                               geom[spf_pkg::CFG_FIT_H], geom[spf_pkg::CFG_SRC_H],
                               geom[spf_pkg::CFG_CANVAS_H], rs, re);
        end
        if (ok) begin
            r.is_empty = 1'b0;
            r.col_start = cs;
            r.col_end = ce;
            r.row_start = rs;
            r.row_end = re;
        end
        return r;
    endfunction

    // Result checker: every strobe is matched against the oldest expectation.
    always @(posedge i_clk) begin
        spf_pkg::t_spf_out exp_fp;
        if (i_rst_n && o_res_vld) begin
            if (footprint_q.size() == 0) begin
                $display("%0t: unexpected footprint beat, got %h", $time, o_res);
                n_fail++;
            end else begin
                exp_fp = footprint_q.pop_front();
                n_beats++;
                if (o_res.is_empty) n_empty++;
                if (o_res !== exp_fp) begin
                    $display("%0t: mismatch expected empty=%0b c=[%0d,%0d) r=[%0d,%0d) col=%h",
                             $time, exp_fp.is_empty, exp_fp.col_start, exp_fp.col_end,
                             exp_fp.row_start, exp_fp.row_end, exp_fp.color_out);
                    $display("%0t:          actual   empty=%0b c=[%0d,%0d) r=[%0d,%0d) col=%h",
                             $time, o_res.is_empty, o_res.col_start, o_res.col_end,
                             o_res.row_start, o_res.row_end, o_res.color_out);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted beat on either side.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_vld) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired at %0t", $time);
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [spf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        geom[idx] = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input logic [15:0] cw, input logic [15:0] ch,
                                input logic [15:0] fx, input logic [15:0] fy,
                                input logic [15:0] fw, input logic [15:0] fh,
                                input logic [15:0] sw, input logic [15:0] sh);
        // Drain in-flight beats before touching the registers.
        wait (footprint_q.size() == 0);
        repeat (LATENCY + 2) @(negedge i_clk);
        write_reg(spf_pkg::CFG_CANVAS_W, cw);
        write_reg(spf_pkg::CFG_CANVAS_H, ch);
        write_reg(spf_pkg::CFG_FIT_X, fx);
        write_reg(spf_pkg::CFG_FIT_Y, fy);
        write_reg(spf_pkg::CFG_FIT_W, fw);
        write_reg(spf_pkg::CFG_FIT_H, fh);
        write_reg(spf_pkg::CFG_SRC_W, sw);
        write_reg(spf_pkg::CFG_SRC_H, sh);
    endtask

    // Presents one pixel beat at the falling edge and holds it until taken.
    // Start is left high so back-to-back beats never toggle it within a step.
    task automatic send_pixel(input spf_pkg::t_spf_in px, input bit check_typed,
                              input spf_pkg::t_spf_out typed);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_pix <= px;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        footprint_q.push_back(check_typed ? typed : pixel_footprint(px));
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    function automatic spf_pkg::t_spf_in mk_pix(input logic [15:0] c,
                                                input logic [15:0] r,
                                                input logic [15:0] k);
        spf_pkg::t_spf_in p;
        p.source_col = c;
        p.source_row = r;
        p.color_in = k;
        return p;
    endfunction

    function automatic spf_pkg::t_spf_out mk_fp(input logic e, input logic [15:0] cs,
                                                input logic [15:0] ce,
                                                input logic [15:0] rs,
                                                input logic [15:0] re,
                                                input logic [15:0] k);
        spf_pkg::t_spf_out f;
        f.is_empty = e;
        f.col_start = cs;
        f.col_end = ce;
        f.row_start = rs;
        f.row_end = re;
        f.color_out = k;
        return f;
    endfunction

    // Directed rows: geometry phase, pixel, and a typed-in answer where obvious.
    typedef struct {
        int                phase;
        spf_pkg::t_spf_in  px;
        bit                typed;
        spf_pkg::t_spf_out fp;
    } t_row;

    t_row dir_rows [$];

    initial begin
        spf_pkg::t_spf_in px;
        int      phase;
        int      sw;
        int      sh;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_pix = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        n_fail = 0;
        n_beats = 0;
        n_empty = 0;
        idle_cycles = 0;
        gaps_on = 1'b0;
        for (int i = 0; i < 8; i++) geom[i] = '0;

        // Phase 0 is the reset geometry, everything empty.
        dir_rows.push_back('{0, mk_pix(16'd0, 16'd0, 16'h1234), 1,
                             mk_fp(1, 0, 0, 0, 0, 16'h1234)});
        dir_rows.push_back('{0, mk_pix(16'hFFFF, 16'hFFFF, 16'hFFFF), 1,
                             mk_fp(1, 0, 0, 0, 0, 16'hFFFF)});
        // Phase 1: 2x upscale of 4x4 into an 8x8 fit on a 16x16 canvas at (1,1).
        dir_rows.push_back('{1, mk_pix(16'd0, 16'd0, 16'h0000), 1,
                             mk_fp(0, 1, 3, 1, 3, 16'h0000)});
        dir_rows.push_back('{1, mk_pix(16'd3, 16'd3, 16'hFFFF), 1,
                             mk_fp(0, 7, 9, 7, 9, 16'hFFFF)});
        dir_rows.push_back('{1, mk_pix(16'd2, 16'd1, 16'hA5A5), 0, '0});
        // Source coordinate outside the image clips away.
        dir_rows.push_back('{1, mk_pix(16'd8, 16'd0, 16'h5A5A), 1,
                             mk_fp(1, 0, 0, 0, 0, 16'h5A5A)});
        dir_rows.push_back('{1, mk_pix(16'hFFFF, 16'd0, 16'h0F0F), 0, '0});
        // Phase 2: downscale 7 -> 3, spans forced to at least one pixel.
        for (int i = 0; i < 4; i++)
            dir_rows.push_back('{2, mk_pix(16'(i * 2), 16'(6 - i), 16'(i)), 0, '0});
        // Phase 3: fit at far corner of a full canvas, end edge clipped.
        dir_rows.push_back('{3, mk_pix(16'd0, 16'd0, 16'h7777), 0, '0});
        dir_rows.push_back('{3, mk_pix(16'd1, 16'd1, 16'h8888), 0, '0});
        dir_rows.push_back('{3, mk_pix(16'hFFFF, 16'hFFFF, 16'h9999), 0, '0});
        // Phase 4: zero canvas clips everything away.
        dir_rows.push_back('{4, mk_pix(16'd0, 16'd0, 16'hBEEF), 1,
                             mk_fp(1, 0, 0, 0, 0, 16'hBEEF)});
        // Phase 5: maximal fit and source sizes, wide intermediates.
        dir_rows.push_back('{5, mk_pix(16'hFFFE, 16'hFFFE, 16'hC3C3), 0, '0});
        dir_rows.push_back('{5, mk_pix(16'hFFFF, 16'h8000, 16'h3C3C), 0, '0});
        dir_rows.push_back('{5, mk_pix(16'h0001, 16'h7FFF, 16'h0001), 0, '0});
        // Phase 6: a zero source height alone empties the result.
        dir_rows.push_back('{6, mk_pix(16'd1, 16'd1, 16'h4321), 1,
                             mk_fp(1, 0, 0, 0, 0, 16'h4321)});

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        phase = 0;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].phase != phase) begin
                stop_sending();
                phase = dir_rows[i].phase;
                case (phase)
                    1: set_geometry(16, 16, 1, 1, 8, 8, 4, 4);
                    2: set_geometry(100, 100, 5, 5, 3, 3, 7, 7);
                    3: set_geometry(16'hFFFF, 16'hFFFF, 16'hFFF0, 16'hFFF0,
                                    40, 40, 2, 2);
                    4: set_geometry(0, 0, 0, 0, 10, 10, 5, 5);
                    5: set_geometry(16'hFFFF, 16'hFFFF, 0, 0,
                                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                    default: set_geometry(50, 50, 0, 0, 20, 20, 10, 0);
                endcase
            end
            send_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].fp);
        end
        stop_sending();

        // Random part: phases of random geometry, mostly small images so that
        // footprints land on the canvas, with a few full-range settings.
        gaps_on = 1'b1;
        for (int ph = 0; ph < 11; ph++) begin
            if (ph == 10) gaps_on = 1'b0;
            if (ph % 4 == 3) begin
                set_geometry(16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom));
            end else begin
                set_geometry(16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                             16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                             16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                             16'($urandom_range(0, 64)), 16'($urandom_range(0, 64)));
            end
            sw = geom[spf_pkg::CFG_SRC_W];
            sh = geom[spf_pkg::CFG_SRC_H];
            for (int k = 0; k < N_RANDOM / 11; k++) begin
                if ($urandom_range(0, 9) < 8 && sw > 0 && sh > 0)
                    px = mk_pix(16'($urandom_range(0, sw - 1)),
                                16'($urandom_range(0, sh - 1)), 16'($urandom));
                else
                    px = mk_pix(16'($urandom), 16'($urandom), 16'($urandom));
                send_pixel(px, 0, '0);
            end
            stop_sending();
        end

        wait (footprint_q.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
        $display("Checked %0d footprint beats (%0d empty) over 18 register settings,",
                 n_beats, n_empty);
        $display("including zero sizes, zero canvas, edge clipping and full-range sizes.");
        if (n_fail == 0 && footprint_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
